// ----- src/lkvc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  // Width of the capacity register and its value after reset.
  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Request type codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // latch the incoming request
    logic lookup;  // search the entries and register the result fields
    logic write;   // apply the update to the entries
  } lkvc_cmd_t;

endpackage

`default_nettype wire

// ----- src/lkvc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lkvc_pkg::lkvc_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next-state logic: one transaction at a time through lookup, write and output.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK:  state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshake outputs and datapath commands.
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign cmd.take   = (state_r == S_IDLE) && in_valid;
  assign cmd.lookup = (state_r == S_LOOK);
  assign cmd.write  = (state_r == S_WRITE);

  // An accepted request produces its result after the lookup and write states.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("result did not appear three cycles after accept");

  // The block never takes a request while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(!in_stall && out_valid))
    else $error("input accepted while result pending");

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

endmodule

`default_nettype wire

// ----- src/lkvc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lkvc_datapath #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lkvc_pkg::lkvc_cmd_t           cmd,
  input  wire logic                          in_req_type,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data,
  output logic                               out_hit,
  output logic [VALUE_BITS-1:0]              out_read_value,
  output logic                               out_evicted
);

  localparam int unsigned AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > lkvc_pkg::CAP_BITS) ? OCC_W : lkvc_pkg::CAP_BITS;

  // Entry storage: one lane per entry.
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] value_r [ENTRIES];
  logic [AGE_W-1:0]      age_r   [ENTRIES];
  logic [OCC_W-1:0]      occ_r;
  logic [lkvc_pkg::CAP_BITS-1:0] cap_r;

  // Latched request.
  logic                  req_put_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_val_r;

  // Lookup results carried into the write cycle.
  logic [ENTRIES-1:0] slot_r;
  logic [AGE_W-1:0]   limit_r;
  logic               inc_all_r;
  logic               insert_r;
  logic               touch_r;
  logic               hit_r;
  logic               evicted_r;
  logic [VALUE_BITS-1:0] read_value_r;

  logic [ENTRIES-1:0]    hit_vec;
  logic [ENTRIES-1:0]    lru_vec;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    inv_vec;
  logic [ENTRIES-1:0]    slot_nxt;
  logic [AGE_W-1:0]      hit_age;
  logic [VALUE_BITS-1:0] hit_value;
  logic [AGE_W-1:0]      occ_last;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  any_hit;
  logic                  full;

  // Effective capacity: zero acts as one, and it saturates at the entry count.
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full     = (CMP_W'(occ_r) >= cap_eff);
  assign occ_last = AGE_W'(occ_r - OCC_W'(1));

  // Parallel match across all lanes; the oldest valid entry has rank occ-1.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req_key_r);
      lru_vec[i] = valid_r[i] && (age_r[i] == occ_last);
    end
  end

  // Lowest free slot.
  assign inv_vec  = ~valid_r;
  assign free_vec = inv_vec & (~inv_vec + ENTRIES'(1));
  assign any_hit  = |hit_vec;

  // Value and age of the matching entry; keys are unique, so an OR mux suffices.
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_age   = hit_age | age_r[i];
        hit_value = hit_value | value_r[i];
      end
    end
  end

  // Slot that this request touches.
  always_comb begin
    if (any_hit) begin
      slot_nxt = hit_vec;
    end else if (req_put_r) begin
      slot_nxt = full ? lru_vec : free_vec;
    end else begin
      slot_nxt = '0;
    end
  end

  // Request latch and capacity register.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_put_r <= (in_req_type == lkvc_pkg::REQ_PUT);
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Lookup stage: register the decision and the result fields.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot_r       <= slot_nxt;
      limit_r      <= any_hit ? hit_age : occ_last;
      inc_all_r    <= !any_hit && !full;
      insert_r     <= req_put_r && !any_hit && !full;
      touch_r      <= any_hit || req_put_r;
      hit_r        <= any_hit;
      evicted_r    <= req_put_r && !any_hit && full;
      read_value_r <= (any_hit && !req_put_r) ? hit_value : '0;
    end
  end

  // Write stage: store the entry and age the entries that were younger.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.write && touch_r) begin
        if (slot_r[i]) begin
          age_r[i] <= '0;
          if (req_put_r) value_r[i] <= req_val_r;
          if (req_put_r && !hit_r) key_r[i] <= req_key_r;
        end else if (valid_r[i] && (inc_all_r || (age_r[i] < limit_r))) begin
          age_r[i] <= age_r[i] + AGE_W'(1);
        end
      end
    end
  end

  // Valid bits and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (cmd.write && insert_r) begin
      valid_r <= valid_r | slot_r;
      occ_r   <= occ_r + OCC_W'(1);
    end
  end

  assign out_hit        = hit_r;
  assign out_read_value = read_value_r;
  assign out_evicted    = evicted_r;

  // Occupancy always equals the number of valid entries.
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy count out of step with valid bits");

  // A put or a hit always lands on exactly one slot.
  a_slot_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && touch_r) |-> $onehot(slot_r))
    else $error("update slot is not one-hot");

  // Occupancy never exceeds the number of entries.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= int'(ENTRIES))
    else $error("occupancy above entry count");

endmodule

`default_nettype wire

// ----- src/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Input channel (in_valid / in_stall): one request per transaction, a get
// (in_req_type 0) or a put (in_req_type 1) with in_key and in_value.
// Output channel (out_valid / out_stall): exactly one result per request,
// giving out_hit, out_read_value (stored value on a get hit, else zero) and
// out_evicted (a put that replaced the least recently used entry).
// Configuration: cfg_wr_en writes cfg_wr_data into the capacity register;
// write it only while no request is in flight.
// After the edge that accepts a request, the controller walks the transaction
// through lookup, write and output states, and out_valid is high in the output
// state. A new request is taken only after the result is taken, so the block
// handles one transaction at a time, and receiver stalls lengthen it.
// While out_stall is high the result holds and no new request is taken.
// A synchronous reset marks every entry invalid, clears occupancy and sets
// the capacity to sixteen; no clearing pass is needed.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [VALUE_BITS-1:0]              out_read_value,
  output logic                               out_evicted,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data
);

  lkvc_pkg::lkvc_cmd_t cmd;

  // Sequencing of each transaction.
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Entry storage, search and update.
  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VAL_W      = 31;
  localparam int unsigned LATENCY    = 3;
  localparam int unsigned HOLD_SPAN  = 60;
  localparam int unsigned STUCK_MAX  = 2000;
  localparam int unsigned POOL_MAX   = 24;
  localparam int unsigned DIR_ROWS   = 25;
  localparam int unsigned PHASES     = 10;

  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [VAL_W-1:0] VAL_ONES = '1;

  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } lookup_result_t;

  typedef struct {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data;
    bit               typed;
    lookup_result_t   want;
  } stim_row_t;

  typedef struct {
    logic [lkvc_pkg::CAP_BITS-1:0] capacity;
    pace_t                         pace;
    int unsigned                   count;
    bit                            hold;
  } phase_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_req_type;
  logic [KEY_W-1:0]    in_key;
  logic [VAL_W-1:0]    in_value;
  logic                out_valid;
  logic                out_stall;
  logic                out_hit;
  logic [VAL_W-1:0]    out_read_value;
  logic                out_evicted;
  logic                cfg_wr_en;
  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wr_data;

  // Hand-typed expectation that travels with the offered transaction.
  bit                  offer_typed;
  lookup_result_t      offer_want;

  // Mirror of the cache contents and recency ranks.
  logic                mirror_valid [SLOTS];
  logic [KEY_W-1:0]    mirror_key [SLOTS];
  logic [VAL_W-1:0]    mirror_value [SLOTS];
  int unsigned         mirror_age [SLOTS];
  int unsigned         mirror_count;
  logic [lkvc_pkg::CAP_BITS-1:0] mirror_capacity;

  lookup_result_t      pending_results [$];
  int unsigned         mismatch_count;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  bit                  hold_request;
  int unsigned         stuck_cycles;

  logic [KEY_W-1:0]    key_pool [POOL_MAX];
  int unsigned         pool_size;

  // Directed requests: empty cache, field extremes, update, then fill and evict.
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{lkvc_pkg::REQ_GET, 32'h0,        31'h0,        1'b1, '{1'b0, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_PUT, 32'h0,        31'h0,        1'b1, '{1'b0, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_PUT, KEY_ONES,     VAL_ONES,     1'b1, '{1'b0, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_GET, KEY_ONES,     31'h0,        1'b1, '{1'b1, VAL_ONES, 1'b0}},
    '{lkvc_pkg::REQ_GET, 32'h0,        VAL_ONES,     1'b1, '{1'b1, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_PUT, 32'h0,        VAL_ONES,     1'b1, '{1'b1, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_GET, 32'h0,        31'h0,        1'b1, '{1'b1, VAL_ONES, 1'b0}},
    '{lkvc_pkg::REQ_GET, 32'h1234_5678, 31'h0,       1'b1, '{1'b0, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_PUT, 32'h1,        31'h2AAA_AAAA, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h2,        31'h5555_5555, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h3,        31'h0000_0003, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h4,        31'h0000_0004, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h5,        31'h0000_0005, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h6,        31'h0000_0006, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h7,        31'h0000_0007, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h8,        31'h0000_0008, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'h9,        31'h0000_0009, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'hA,        31'h0000_000A, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'hB,        31'h0000_000B, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'hC,        31'h0000_000C, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'hD,        31'h0000_000D, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'hE,        31'h0000_000E, 1'b0, '0},
    '{lkvc_pkg::REQ_PUT, 32'hF,        31'h0000_000F, 1'b1, '{1'b0, 31'h0, 1'b1}},
    '{lkvc_pkg::REQ_GET, KEY_ONES,     31'h0,        1'b1, '{1'b0, 31'h0, 1'b0}},
    '{lkvc_pkg::REQ_GET, 32'h0,        31'h0,        1'b1, '{1'b1, VAL_ONES, 1'b0}}
  };

  // Random phases: capacity setting, idling pattern, request count, receiver hold.
  phase_t phase_plan [PHASES] = '{
    '{5'd16, PACE_NONE, 120, 1'b1},
    '{5'd1,  PACE_SEND, 120, 1'b0},
    '{5'd0,  PACE_RECV, 120, 1'b0},
    '{5'd31, PACE_BOTH, 120, 1'b0},
    '{5'd5,  PACE_NONE, 120, 1'b0},
    '{5'd2,  PACE_SEND, 120, 1'b0},
    '{5'd17, PACE_RECV, 120, 1'b0},
    '{5'd8,  PACE_BOTH, 120, 1'b0},
    '{5'd3,  PACE_NONE, 120, 1'b0},
    '{5'd16, PACE_SEND, 120, 1'b0}
  };

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Make slot s the most recent; valid entries younger than limit age by one.
  function automatic void refresh_slot(int unsigned s, int unsigned limit);
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (mirror_valid[i] && i != s && mirror_age[i] < limit) begin
        mirror_age[i]++;
      end
    end
    mirror_age[s] = 0;
  endfunction

  // Apply one get or put to the mirror and return the result it produces.
  function automatic lookup_result_t cache_access(logic kind, logic [KEY_W-1:0] k,
                                                  logic [VAL_W-1:0] v);
    lookup_result_t res;
    int unsigned    slot;
    int unsigned    limit;
    bit             found;
    bit             have;
    res   = '0;
    slot  = 0;
    found = 1'b0;
    have  = 1'b0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (!found && mirror_valid[i] && mirror_key[i] == k) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (kind == lkvc_pkg::REQ_PUT) begin
        mirror_value[slot] = v;
      end else begin
        res.read_value = mirror_value[slot];
      end
      refresh_slot(slot, mirror_age[slot]);
      return res;
    end
    if (kind == lkvc_pkg::REQ_GET) begin
      return res;
    end
    // Zero behaves as one, anything above the slot count saturates.
    limit = 32'(mirror_capacity);
    if (limit == 0) begin
      limit = 1;
    end
    if (limit > SLOTS) begin
      limit = SLOTS;
    end
    if (mirror_count >= limit) begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (mirror_valid[i] && (!have || mirror_age[i] > mirror_age[slot])) begin
          slot = i;
          have = 1'b1;
        end
      end
      res.evicted        = 1'b1;
      mirror_key[slot]   = k;
      mirror_value[slot] = v;
      refresh_slot(slot, mirror_age[slot]);
    end else begin
      have = 1'b0;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (!have && !mirror_valid[i]) begin
          slot = i;
          have = 1'b1;
        end
      end
      mirror_valid[slot] = 1'b1;
      mirror_key[slot]   = k;
      mirror_value[slot] = v;
      refresh_slot(slot, 32'hFFFF_FFFF);
      mirror_count++;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Offer one transaction, after an optional random gap, and wait until taken.
  task automatic send_request(logic kind, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              bit typed, lookup_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_key      <= k;
    in_value    <= v;
    offer_typed <= typed;
    offer_want  <= want;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Let every outstanding transaction finish, then write the capacity.
  task automatic write_capacity(logic [lkvc_pkg::CAP_BITS-1:0] cap);
    in_valid <= 1'b0;
    // Wait for an edge first, so the last accepted transaction is already queued.
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    mirror_capacity = cap;
  endtask

  task automatic set_pace(pace_t pace);
    send_idle_pct  = (pace == PACE_SEND) ? 53 : (pace == PACE_BOTH) ? 24 : 0;
    recv_stall_pct = (pace == PACE_RECV) ? 53 : (pace == PACE_BOTH) ? 24 : 0;
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_SPAN;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Predict on each accepted request and check each accepted result.
  always @(posedge clk) begin
    lookup_result_t predicted;
    lookup_result_t oldest;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = cache_access(in_req_type, in_key, in_value);
        pending_results.push_back(offer_typed ? offer_want : predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {31'h0, out_hit}, 32'h0);
        end else begin
          oldest = pending_results.pop_front();
          if (out_hit !== oldest.hit) begin
            report_mismatch("hit", {31'h0, out_hit}, {31'h0, oldest.hit});
          end
          if (out_read_value !== oldest.read_value) begin
            report_mismatch("read_value", {1'b0, out_read_value}, {1'b0, oldest.read_value});
          end
          if (out_evicted !== oldest.evicted) begin
            report_mismatch("evicted", {31'h0, out_evicted}, {31'h0, oldest.evicted});
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned    eff_cap;
    logic           kind;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    mismatch_count  = 0;
    stuck_cycles    = 0;
    hold_request    = 1'b0;
    mirror_count    = 0;
    mirror_capacity = lkvc_pkg::CAP_RESET;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_key[i]   = '0;
      mirror_value[i] = '0;
      mirror_age[i]   = 0;
    end
    set_pace(PACE_NONE);
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= lkvc_pkg::REQ_GET;
    in_key      <= '0;
    in_value    <= '0;
    offer_typed <= 1'b0;
    offer_want  <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the capacity left by reset.
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].kind, directed_rows[r].key, directed_rows[r].data,
                   directed_rows[r].typed, directed_rows[r].want);
    end

    // Random requests over a small key pool, so hits and evictions are frequent.
    foreach (phase_plan[p]) begin
      write_capacity(phase_plan[p].capacity);
      set_pace(phase_plan[p].pace);
      if (phase_plan[p].hold) begin
        hold_request = 1'b1;
      end
      eff_cap = (phase_plan[p].capacity == 0) ? 1 :
                (phase_plan[p].capacity > SLOTS) ? SLOTS : 32'(phase_plan[p].capacity);
      pool_size = eff_cap + 4;
      for (int unsigned i = 0; i < POOL_MAX; i++) begin
        key_pool[i] = $urandom;
      end
      for (int unsigned n = 0; n < phase_plan[p].count; n++) begin
        kind = $urandom_range(1) ? lkvc_pkg::REQ_PUT : lkvc_pkg::REQ_GET;
        if ($urandom_range(9) == 0) begin
          k = $urandom;
        end else begin
          k = key_pool[$urandom_range(pool_size - 1)];
        end
        case ($urandom_range(15))
          0: begin
            v = '0;
          end
          1: begin
            v = VAL_ONES;
          end
          default: begin
            v = VAL_W'($urandom);
          end
        endcase
        send_request(kind, k, v, 1'b0, '0);
      end
    end

    // Drain, then keep the clock running to catch anything stray.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache.sv
bench/testbench.sv
